FILE: hw/rtl/rmpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpm_pkg
// Shared widths, register indexes, reset values and controller states of the level meter.
// ----------------------------------------------------------------------------
package rmpm_pkg;

    localparam int MAX_CHANNELS     = 32;
    localparam int CH_BITS          = $clog2(MAX_CHANNELS);
    localparam int CH_COUNT_BITS    = 6;
    localparam int FRAME_COUNT_BITS = 16;
    localparam int SAMPLE_BITS      = 16;
    localparam int MAG_BITS         = 16;
    localparam int SQ_BITS          = 31;
    localparam int SUM_BITS         = 46;
    localparam int SMS_BITS         = 31;
    localparam int ALPHA_BITS       = 16;
    localparam int LEVEL_BITS       = 16;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_ADDR_BITS    = 2;
    localparam int OUT_DATA_BITS    = 40;

    localparam logic [CFG_ADDR_BITS-1:0] REG_CHANNEL_COUNT    = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAMES_PER_BLOCK = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RMS_ALPHA        = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PEAK_ALPHA       = 2'd3;

    localparam logic [CH_COUNT_BITS-1:0]    RST_CHANNEL_COUNT    = 6'd2;
    localparam logic [FRAME_COUNT_BITS-1:0] RST_FRAMES_PER_BLOCK = 16'd480;
    localparam logic [ALPHA_BITS-1:0]       RST_RMS_ALPHA        = 16'd60302;
    localparam logic [ALPHA_BITS-1:0]       RST_PEAK_ALPHA       = 16'd64238;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQ   = 7'b0000010,
        ST_ACC  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_MAC  = 7'b0010000,
        ST_SQRT = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

endpackage

FILE: hw/rtl/multichannel_rms_peak_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_rms_peak_meter_core
// Per-channel block RMS and held-peak meter over interleaved PCM samples.
// ----------------------------------------------------------------------------
// A sample passes through magnitude, square and accumulate steps; s_tready is
// low meanwhile. When a block closes, each channel is updated in turn:
// bit-serial divide for the block mean, bit-serial smoothing and peak decay,
// digit-serial square root, then the transfer of the result, which waits for
// m_tready. The walk runs one channel at a time through these shared serial
// units; no sample is taken until the last channel result has been
// transferred.
// ----------------------------------------------------------------------------
module multichannel_rms_peak_meter_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [rmpm_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [rmpm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [rmpm_pkg::SAMPLE_BITS-1:0]      s_tdata,  // [15:0] sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [4:0] channel, [20:5] rms_level, [36:21] peak_level, [39:37] zero
    output logic [rmpm_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    output logic                                  m_tlast   // last_channel
);
    import rmpm_pkg::*;

    state_t state_reg;
    logic   start_reg;

    logic [CH_COUNT_BITS-1:0]    ch_count_reg;
    logic [FRAME_COUNT_BITS-1:0] fpb_reg;
    logic [ALPHA_BITS-1:0]       rms_alpha_reg;
    logic [ALPHA_BITS-1:0]       peak_alpha_reg;

    logic [SUM_BITS-1:0] sum_mem  [MAX_CHANNELS];
    logic [MAG_BITS-1:0] peak_mem [MAX_CHANNELS];
    logic [SMS_BITS-1:0] sms_mem  [MAX_CHANNELS];
    logic [MAG_BITS-1:0] held_mem [MAX_CHANNELS];

    logic [CH_BITS-1:0]          ch_pos_reg;
    logic [FRAME_COUNT_BITS-1:0] fr_pos_reg;
    logic [FRAME_COUNT_BITS-1:0] frames_reg;
    logic [CH_BITS-1:0]          k_reg;
    logic [MAG_BITS-1:0]         mag_reg;
    logic [SQ_BITS-1:0]          sq_reg;

    logic [CH_BITS-1:0]    out_ch_reg;
    logic [LEVEL_BITS-1:0] out_rms_reg;
    logic [LEVEL_BITS-1:0] out_peak_reg;
    logic                  out_last_reg;

    logic [CH_COUNT_BITS-1:0]    nch;
    logic [FRAME_COUNT_BITS-1:0] nfr;
    logic                        ch_wrap;
    logic                        blk_end;
    logic                        k_last;
    logic [SAMPLE_BITS-1:0]      s_mag;

    logic                  div_done;
    logic [SMS_BITS-1:0]   mean;
    logic                  mac_done;
    logic [SMS_BITS-1:0]   sms_new;
    logic [MAG_BITS-1:0]   decayed;
    logic                  sqrt_done;
    logic [LEVEL_BITS-1:0] root;

    always_comb begin
        nch = (ch_count_reg == '0) ? CH_COUNT_BITS'(1) :
              (ch_count_reg > CH_COUNT_BITS'(MAX_CHANNELS)) ?
              CH_COUNT_BITS'(MAX_CHANNELS) : ch_count_reg;
        nfr = (fpb_reg == '0) ? FRAME_COUNT_BITS'(1) : fpb_reg;
        ch_wrap = ({1'b0, ch_pos_reg} + CH_COUNT_BITS'(1)) >= nch;
        blk_end = ch_wrap &&
                  (({1'b0, fr_pos_reg} + 17'd1) >= {1'b0, nfr});
        k_last  = ({1'b0, k_reg} + CH_COUNT_BITS'(1)) >= nch;
        s_mag   = s_tdata[SAMPLE_BITS-1] ? (~s_tdata + 1'b1) : s_tdata;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {3'b000, out_peak_reg, out_rms_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_count_reg   <= RST_CHANNEL_COUNT;
            fpb_reg        <= RST_FRAMES_PER_BLOCK;
            rms_alpha_reg  <= RST_RMS_ALPHA;
            peak_alpha_reg <= RST_PEAK_ALPHA;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CHANNEL_COUNT:    ch_count_reg   <= cfg_data[CH_COUNT_BITS-1:0];
                REG_FRAMES_PER_BLOCK: fpb_reg        <= cfg_data;
                REG_RMS_ALPHA:        rms_alpha_reg  <= cfg_data;
                REG_PEAK_ALPHA:       peak_alpha_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            start_reg  <= 1'b0;
            ch_pos_reg <= '0;
            fr_pos_reg <= '0;
            k_reg      <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                sum_mem[i]  <= '0;
                peak_mem[i] <= '0;
                sms_mem[i]  <= '0;
                held_mem[i] <= '0;
            end
        end else begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mag_reg   <= s_mag;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    sq_reg    <= SQ_BITS'({16'd0, mag_reg} * {16'd0, mag_reg});
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    sum_mem[ch_pos_reg] <= sum_mem[ch_pos_reg] + SUM_BITS'(sq_reg);
                    if (mag_reg > peak_mem[ch_pos_reg]) begin
                        peak_mem[ch_pos_reg] <= mag_reg;
                    end
                    if (!ch_wrap) begin
                        ch_pos_reg <= ch_pos_reg + 1'b1;
                        state_reg  <= ST_IDLE;
                    end else if (!blk_end) begin
                        ch_pos_reg <= '0;
                        fr_pos_reg <= fr_pos_reg + 1'b1;
                        state_reg  <= ST_IDLE;
                    end else begin
                        ch_pos_reg <= '0;
                        fr_pos_reg <= '0;
                        frames_reg <= fr_pos_reg + 1'b1;
                        k_reg      <= '0;
                        start_reg  <= 1'b1;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        start_reg <= 1'b1;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (mac_done) begin
                        sms_mem[k_reg]  <= sms_new;
                        held_mem[k_reg] <= (peak_mem[k_reg] > decayed) ?
                                           peak_mem[k_reg] : decayed;
                        start_reg <= 1'b1;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        out_ch_reg   <= k_reg;
                        out_rms_reg  <= root;
                        out_peak_reg <= held_mem[k_reg];
                        out_last_reg <= k_last;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (out_last_reg) begin
                            for (int i = 0; i < MAX_CHANNELS; i++) begin
                                sum_mem[i]  <= '0;
                                peak_mem[i] <= '0;
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            start_reg <= 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    rmpm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg && (state_reg == ST_DIV)),
        .dividend (sum_mem[k_reg]),
        .divisor  (frames_reg),
        .quotient (mean),
        .done     (div_done)
    );

    rmpm_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start_reg && (state_reg == ST_MAC)),
        .sms_in      (sms_mem[k_reg]),
        .mean_in     (mean),
        .held_in     (held_mem[k_reg]),
        .rms_alpha   (rms_alpha_reg),
        .peak_alpha  (peak_alpha_reg),
        .sms_out     (sms_new),
        .decayed_out (decayed),
        .done        (mac_done)
    );

    rmpm_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg && (state_reg == ST_SQRT)),
        .radicand (sms_mem[k_reg]),
        .root     (root),
        .done     (sqrt_done)
    );

endmodule

FILE: hw/rtl/rmpm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpm_divider
// Bit-serial restoring divider: block square sum over frame count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmpm_divider (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [rmpm_pkg::SUM_BITS-1:0]          dividend,
    input  logic [rmpm_pkg::FRAME_COUNT_BITS-1:0]  divisor,
    output logic [rmpm_pkg::SMS_BITS-1:0]          quotient,
    output logic                                   done
);
    import rmpm_pkg::*;

    localparam int CNT_BITS = $clog2(SUM_BITS);

    logic [SUM_BITS-1:0]         num_reg;
    logic [FRAME_COUNT_BITS:0]   rem_reg;
    logic [FRAME_COUNT_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0]         cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [FRAME_COUNT_BITS:0]   trial;
    logic                        fits;

    always_comb begin
        trial = {rem_reg[FRAME_COUNT_BITS-1:0], num_reg[SUM_BITS-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(SUM_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            num_reg <= {num_reg[SUM_BITS-2:0], fits};
        end
    end

    assign quotient = num_reg[SMS_BITS-1:0];
    assign done     = done_reg;

endmodule

FILE: hw/rtl/rmpm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpm_mac
// Bit-serial smoothing unit: mixes the block mean into the smoothed mean
// square and decays the held peak, one coefficient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rmpm_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [rmpm_pkg::SMS_BITS-1:0]    sms_in,
    input  logic [rmpm_pkg::SMS_BITS-1:0]    mean_in,
    input  logic [rmpm_pkg::MAG_BITS-1:0]    held_in,
    input  logic [rmpm_pkg::ALPHA_BITS-1:0]  rms_alpha,
    input  logic [rmpm_pkg::ALPHA_BITS-1:0]  peak_alpha,
    output logic [rmpm_pkg::SMS_BITS-1:0]    sms_out,
    output logic [rmpm_pkg::MAG_BITS-1:0]    decayed_out,
    output logic                             done
);
    import rmpm_pkg::*;

    localparam int CB       = ALPHA_BITS + 1;
    localparam int RACC     = SMS_BITS + CB;
    localparam int PACC     = MAG_BITS + ALPHA_BITS;
    localparam int CNT_BITS = $clog2(CB);

    logic [SMS_BITS-1:0] sms_reg;
    logic [SMS_BITS-1:0] mean_reg;
    logic [MAG_BITS-1:0] held_reg;
    logic [CB-1:0]       a_reg;
    logic [CB-1:0]       b_reg;
    logic [CB-1:0]       p_reg;
    logic [RACC-1:0]     racc_reg;
    logic [PACC-1:0]     pacc_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(CB - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sms_reg  <= sms_in;
            mean_reg <= mean_in;
            held_reg <= held_in;
            a_reg    <= {1'b0, rms_alpha};
            b_reg    <= CB'(1 << ALPHA_BITS) - {1'b0, rms_alpha};
            p_reg    <= {1'b0, peak_alpha};
            racc_reg <= '0;
            pacc_reg <= '0;
        end else if (busy_reg) begin
            racc_reg <= {racc_reg[RACC-2:0], 1'b0}
                      + (a_reg[CB-1] ? RACC'(sms_reg)  : RACC'(0))
                      + (b_reg[CB-1] ? RACC'(mean_reg) : RACC'(0));
            pacc_reg <= {pacc_reg[PACC-2:0], 1'b0}
                      + (p_reg[CB-1] ? PACC'(held_reg) : PACC'(0));
            a_reg    <= {a_reg[CB-2:0], 1'b0};
            b_reg    <= {b_reg[CB-2:0], 1'b0};
            p_reg    <= {p_reg[CB-2:0], 1'b0};
        end
    end

    assign sms_out     = racc_reg[ALPHA_BITS +: SMS_BITS];
    assign decayed_out = pacc_reg[ALPHA_BITS +: MAG_BITS];
    assign done        = done_reg;

endmodule

FILE: hw/rtl/rmpm_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpm_isqrt
// Digit-serial floor square root, one base-4 digit of the radicand per cycle.
// ----------------------------------------------------------------------------
module rmpm_isqrt (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [rmpm_pkg::SMS_BITS-1:0]    radicand,
    output logic [rmpm_pkg::LEVEL_BITS-1:0]  root,
    output logic                             done
);
    import rmpm_pkg::*;

    localparam int RW       = 2 * LEVEL_BITS;
    localparam int REMW     = LEVEL_BITS + 2;
    localparam int CNT_BITS = $clog2(LEVEL_BITS);

    logic [RW-1:0]         val_reg;
    logic [REMW-1:0]       rem_reg;
    logic [LEVEL_BITS-1:0] root_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [REMW-1:0]       rem_sh;
    logic [REMW-1:0]       trial;
    logic                  fits;

    always_comb begin
        rem_sh = {rem_reg[REMW-3:0], val_reg[RW-1 -: 2]};
        trial  = {root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(LEVEL_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= RW'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[RW-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[LEVEL_BITS-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/rmpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmpm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
module rmpm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rmpm_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input logic                                m_tlast
);
    import rmpm_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_input_during_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("sample transfer not followed by processing");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:5] <= 16'd32768) && (m_tdata[36:21] <= 16'd32768))
        else $error("level above full scale");

endmodule

bind multichannel_rms_peak_meter_core rmpm_checker u_rmpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
